@@ rtl/core/qrs_pkg.sv @@
package qrs_pkg;

  localparam int SQ_STAGES = 9;
  localparam int SQ_STEPS  = 2;
  localparam int DIV_STAGES = 9;
  localparam int DIV_STEPS  = 4;

  localparam logic [1:0] CNT_NONE   = 2'd0;
  localparam logic [1:0] CNT_DOUBLE = 2'd1;
  localparam logic [1:0] CNT_TWO    = 2'd2;

  typedef struct packed {
    logic               valid;
    logic               invalid;
    logic [1:0]         count;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } side_t;

  typedef struct packed {
    logic       valid;
    logic       invalid;
    logic [1:0] count;
    logic       neg_m;
    logic       neg_p;
  } flag_t;

endpackage

@@ rtl/core/qrs_front.sv @@
module qrs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] coef_a,
  input  logic signed [15:0] coef_b,
  input  logic signed [15:0] coef_c,
  output qrs_pkg::side_t     side,
  output logic [35:0]        disc
);

  logic               v1;
  logic signed [15:0] a1, b1;
  logic signed [31:0] bb, ac;
  logic signed [33:0] d;
  logic [1:0]         cnt;

  assign d = 34'(bb) - $signed({ac, 2'b00});

  always_comb begin
    if (a1 == 16'sd0) begin
      cnt = qrs_pkg::CNT_NONE;
    end else if (d < 0) begin
      cnt = qrs_pkg::CNT_NONE;
    end else if (d == 34'sd0) begin
      cnt = qrs_pkg::CNT_DOUBLE;
    end else begin
      cnt = qrs_pkg::CNT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      side.valid <= v1;
    end
    if (en) begin
      a1 <= coef_a;
      b1 <= coef_b;
      bb <= 32'(coef_b) * 32'(coef_b);
      ac <= 32'(coef_a) * 32'(coef_c);
      side.invalid <= (a1 == 16'sd0);
      side.count <= cnt;
      side.a <= a1;
      side.b <= b1;
      disc <= (cnt == qrs_pkg::CNT_TWO) ? {2'b00, d} : 36'd0;
    end
  end

endmodule

@@ rtl/core/qrs_sqrt.sv @@
module qrs_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  qrs_pkg::side_t side_in,
  input  logic [35:0]    disc,
  output qrs_pkg::side_t side_out,
  output logic [17:0]    root
);

  typedef struct packed {
    logic [19:0] r;
    logic [17:0] q;
    logic [35:0] v;
  } sq_t;

  function automatic sq_t sq_step(sq_t x);
    sq_t         y;
    logic [19:0] trial;
    y = x;
    for (int i = 0; i < qrs_pkg::SQ_STEPS; i++) begin
      y.r = {y.r[17:0], y.v[35:34]};
      y.v = {y.v[33:0], 2'b00};
      trial = {y.q, 2'b01};
      if (y.r >= trial) begin
        y.r = y.r - trial;
        y.q = {y.q[16:0], 1'b1};
      end else begin
        y.q = {y.q[16:0], 1'b0};
      end
    end
    return y;
  endfunction

  sq_t            st [qrs_pkg::SQ_STAGES+1];
  qrs_pkg::side_t sd [qrs_pkg::SQ_STAGES+1];

  assign st[0] = '{r: 20'd0, q: 18'd0, v: disc};
  assign sd[0] = side_in;

  for (genvar k = 1; k <= qrs_pkg::SQ_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k].valid <= 1'b0;
      end else if (en) begin
        sd[k].valid <= sd[k-1].valid;
      end
      if (en) begin
        st[k] <= sq_step(st[k-1]);
        sd[k].invalid <= sd[k-1].invalid;
        sd[k].count <= sd[k-1].count;
        sd[k].a <= sd[k-1].a;
        sd[k].b <= sd[k-1].b;
      end
    end
  end

  assign side_out = sd[qrs_pkg::SQ_STAGES];
  assign root = st[qrs_pkg::SQ_STAGES].q;

endmodule

@@ rtl/core/qrs_div.sv @@
module qrs_div (
  input  logic        clk,
  input  logic        en,
  input  logic [35:0] num,
  input  logic [16:0] den,
  output logic [35:0] quo
);

  typedef struct packed {
    logic [17:0] rem;
    logic [35:0] q;
    logic [35:0] n;
    logic [16:0] d;
  } dv_t;

  function automatic dv_t dv_step(dv_t x);
    dv_t y;
    y = x;
    for (int i = 0; i < qrs_pkg::DIV_STEPS; i++) begin
      y.rem = {y.rem[16:0], y.n[35]};
      y.n = {y.n[34:0], 1'b0};
      if (y.rem >= {1'b0, y.d}) begin
        y.rem = y.rem - {1'b0, y.d};
        y.q = {y.q[34:0], 1'b1};
      end else begin
        y.q = {y.q[34:0], 1'b0};
      end
    end
    return y;
  endfunction

  dv_t st [qrs_pkg::DIV_STAGES+1];

  assign st[0] = '{rem: 18'd0, q: 36'd0, n: num, d: den};

  for (genvar k = 1; k <= qrs_pkg::DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= dv_step(st[k-1]);
      end
    end
  end

  assign quo = st[qrs_pkg::DIV_STAGES].q;

endmodule

@@ rtl/core/quadratic_root_solver.sv @@
// Quadratic root solver, real roots of a*x^2 + b*x + c = 0.
// Input channel: in_valid / in_stall with coef_a, coef_b, coef_c (signed Q8.8).
// Output channel: out_valid / out_stall with root_count, invalid_a,
// root_minus and root_plus (signed Q16.16, saturated).
// Fully pipelined: one word accepted every cycle while the output is not stalled
// (2 multiply/discriminant stages, 9 square root stages at 2 root bits each,
// 1 numerator stage, 9 divider stages at 4 quotient bits each, 1 output stage).
// Throughput is one word per cycle unless out_stall holds the pipeline.
// Reset (rst, synchronous) empties the pipeline; no output word is valid
// until a new input word has passed through.
// When out_stall is high with a word waiting, the whole pipeline holds and
// in_stall goes high; nothing is lost or repeated. Empty slots are not
// squeezed out, so bubbles keep their spacing.
module quadratic_root_solver (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] coef_a,
  input  logic signed [15:0] coef_b,
  input  logic signed [15:0] coef_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         root_count,
  output logic               invalid_a,
  output logic signed [31:0] root_minus,
  output logic signed [31:0] root_plus
);

  logic           en;
  qrs_pkg::side_t f_side, s_side;
  logic [35:0]    f_disc;
  logic [17:0]    s_root;

  assign en = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  qrs_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .side(f_side), .disc(f_disc)
  );

  qrs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .side_in(f_side), .disc(f_disc),
    .side_out(s_side), .root(s_root)
  );

  // numerator and divisor magnitudes
  logic signed [18:0] nm, np;
  logic [16:0]        p_mag_m, p_mag_p, p_den;
  qrs_pkg::flag_t     p_flag;

  assign nm = -19'(s_side.b) - $signed({1'b0, s_root});
  assign np = -19'(s_side.b) + $signed({1'b0, s_root});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_flag.valid <= 1'b0;
    end else if (en) begin
      p_flag.valid <= s_side.valid;
    end
    if (en) begin
      p_flag.invalid <= s_side.invalid;
      p_flag.count <= s_side.count;
      p_flag.neg_m <= nm[18] ^ s_side.a[15];
      p_flag.neg_p <= np[18] ^ s_side.a[15];
      p_mag_m <= nm[18] ? 17'(-nm) : nm[16:0];
      p_mag_p <= np[18] ? 17'(-np) : np[16:0];
      p_den <= s_side.a[15] ? 17'(-{s_side.a, 1'b0}) : 17'({s_side.a, 1'b0});
    end
  end

  logic [35:0] q_m, q_p;

  qrs_div u_div_m (
    .clk(clk), .en(en), .num({3'b000, p_mag_m, 16'h0000}), .den(p_den), .quo(q_m)
  );

  qrs_div u_div_p (
    .clk(clk), .en(en), .num({3'b000, p_mag_p, 16'h0000}), .den(p_den), .quo(q_p)
  );

  qrs_pkg::flag_t fl [qrs_pkg::DIV_STAGES+1];
  assign fl[0] = p_flag;

  for (genvar k = 1; k <= qrs_pkg::DIV_STAGES; k++) begin : g_flag
    always_ff @(posedge clk) begin
      if (rst) begin
        fl[k].valid <= 1'b0;
      end else if (en) begin
        fl[k].valid <= fl[k-1].valid;
      end
      if (en) begin
        fl[k].invalid <= fl[k-1].invalid;
        fl[k].count <= fl[k-1].count;
        fl[k].neg_m <= fl[k-1].neg_m;
        fl[k].neg_p <= fl[k-1].neg_p;
      end
    end
  end

  function automatic logic [31:0] sat_root(logic [35:0] q, logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (q > 36'h0_8000_0000) ? 32'h8000_0000 : 32'(-q);
    end else begin
      r = (q > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  qrs_pkg::flag_t lf;
  logic           none;

  assign lf = fl[qrs_pkg::DIV_STAGES];
  assign none = (lf.count == qrs_pkg::CNT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lf.valid;
    end
    if (en) begin
      root_count <= lf.count;
      invalid_a <= lf.invalid;
      root_minus <= none ? 32'sd0 : $signed(sat_root(q_m, lf.neg_m));
      root_plus <= none ? 32'sd0 : $signed(sat_root(q_p, lf.neg_p));
    end
  end

endmodule

@@ rtl/core/qrs_checker.sv @@
module qrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         root_count,
  input logic               invalid_a,
  input logic signed [31:0] root_minus,
  input logic signed [31:0] root_plus
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(root_minus) && $stable(root_plus))
    else $error("stalled output word changed");

  a_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_a |-> root_count == qrs_pkg::CNT_NONE)
    else $error("invalid_a with nonzero root count");

  a_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_count == qrs_pkg::CNT_NONE |-> root_minus == 32'sd0 && root_plus == 32'sd0)
    else $error("no roots but nonzero root fields");

  a_double: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_count == qrs_pkg::CNT_DOUBLE |-> root_minus == root_plus)
    else $error("double root fields differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .root_count(root_count), .invalid_a(invalid_a),
  .root_minus(root_minus), .root_plus(root_plus)
);
